FILE: rtl/mlpe_pkg.sv
// shared types and constants for the morse letter pulse encoder
// no dependencies; imported by every module of the block
package mlpe_pkg;

    localparam int UNIT_W      = 16;
    localparam int DUR_W       = 19;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              text_end;
    } item_t;

    typedef struct packed {
        logic             lamp_on;
        logic [DUR_W-1:0] duration;
        logic             last;
    } result_t;

    // classified character waiting for the sequencer
    typedef struct packed {
        logic       letter;
        logic [2:0] len;
        logic [3:0] pat;     // first element in bit 3, 1 = dash
        logic [3:0] count;   // segments this request produces
    } desc_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              not_empty;
    } queue_status_t;

endpackage

FILE: rtl/mlpe_front.sv
// front end: folds case, looks up the letter pattern and counts segments
// depends on mlpe_pkg
module mlpe_front
    import mlpe_pkg::*;
(
    input  logic  start,
    input  logic  busy,
    input  item_t item,
    output logic  push,
    output desc_t desc
);

    // top three bits element count, low nibble pattern, last element in bit 0
    function automatic logic [6:0] letter_code(input logic [4:0] idx);
        logic [6:0] lut;
        case (idx)
            5'd0:    lut = 7'h21;
            5'd1:    lut = 7'h48;
            5'd2:    lut = 7'h4A;
            5'd3:    lut = 7'h34;
            5'd4:    lut = 7'h10;
            5'd5:    lut = 7'h42;
            5'd6:    lut = 7'h36;
            5'd7:    lut = 7'h40;
            5'd8:    lut = 7'h20;
            5'd9:    lut = 7'h47;
            5'd10:   lut = 7'h35;
            5'd11:   lut = 7'h44;
            5'd12:   lut = 7'h23;
            5'd13:   lut = 7'h22;
            5'd14:   lut = 7'h37;
            5'd15:   lut = 7'h46;
            5'd16:   lut = 7'h4D;
            5'd17:   lut = 7'h32;
            5'd18:   lut = 7'h30;
            5'd19:   lut = 7'h11;
            5'd20:   lut = 7'h31;
            5'd21:   lut = 7'h41;
            5'd22:   lut = 7'h33;
            5'd23:   lut = 7'h49;
            5'd24:   lut = 7'h4B;
            5'd25:   lut = 7'h4C;
            default: lut = 7'h00;
        endcase
        return lut;
    endfunction

    logic [CHAR_W-1:0] folded;
    logic [CHAR_W-1:0] offset;
    logic [6:0]        code;
    logic              is_letter;
    logic              is_space;
    logic [2:0]        len;
    logic [3:0]        pat_aligned;
    logic [3:0]        count;

    always_comb
    begin
        folded = item.character;
        if (item.character >= CHAR_UPPER_A && item.character <= CHAR_UPPER_Z)
        begin
            folded = item.character | CHAR_SPACE;
        end
        is_letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
        is_space  = (folded == CHAR_SPACE);
        offset    = folded - CHAR_LOWER_A;
        code      = letter_code(offset[4:0]);
        len       = code[6:4];
        // left-align so the first element sits in bit 3
        pat_aligned = code[3:0] << (3'd4 - len);

        if (is_letter)
        begin
            count = {len, 1'b0} + 4'd1 + {3'b000, item.text_end};
        end
        else if (is_space)
        begin
            count = 4'd1 + {3'b000, item.text_end};
        end
        else
        begin
            count = {3'b000, item.text_end};
        end
    end

    assign desc.letter = is_letter;
    assign desc.len    = len;
    assign desc.pat    = pat_aligned;
    assign desc.count  = count;

    // characters that give no segment never enter the queue
    assign push = start && !busy && (count != 4'd0);

endmodule

FILE: rtl/mlpe_queue.sv
// short request queue between the front end and the segment sequencer
// depends on mlpe_pkg
module mlpe_queue
    import mlpe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  desc_t         push_desc,
    input  logic          pop,
    output desc_t         head,
    output queue_status_t status
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);

endmodule

FILE: rtl/mlpe_back.sv
// back end: walks the head request one segment per cycle, registered output
// depends on mlpe_pkg
module mlpe_back
    import mlpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [UNIT_W-1:0] unit_ticks,
    input  desc_t             head,
    input  logic              not_empty,
    output logic              pop,
    output logic              result_valid,
    output result_t           result
);

    logic [3:0]       idx_reg;
    logic [3:0]       idx_next;
    logic             valid_reg;
    result_t          result_reg;
    result_t          result_next;
    logic [DUR_W-1:0] dur1;
    logic [DUR_W-1:0] dur3;
    logic [DUR_W-1:0] dur6;
    logic [3:0]       elem_end;
    logic             seg_last;

    always_comb
    begin
        dur1     = {{(DUR_W-UNIT_W){1'b0}}, unit_ticks};
        dur3     = dur1 + {dur1[DUR_W-2:0], 1'b0};
        dur6     = {dur3[DUR_W-2:0], 1'b0};
        elem_end = {head.len, 1'b0};
        seg_last = (idx_reg == head.count - 4'd1);

        result_next.last = seg_last;
        if (head.letter && idx_reg < elem_end)
        begin
            // even index: the mark, odd index: one unit dark after it
            result_next.lamp_on  = !idx_reg[0];
            if (idx_reg[0])
            begin
                result_next.duration = dur1;
            end
            else if (head.pat[~idx_reg[2:1]])
            begin
                result_next.duration = dur3;
            end
            else
            begin
                result_next.duration = dur1;
            end
        end
        else if (head.letter && idx_reg == elem_end)
        begin
            result_next.lamp_on  = 1'b0;
            result_next.duration = dur3;
        end
        else
        begin
            // space gap or word gap
            result_next.lamp_on  = 1'b0;
            result_next.duration = dur6;
        end

        pop      = not_empty && seg_last;
        idx_next = idx_reg;
        if (not_empty)
        begin
            idx_next = seg_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (not_empty)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/morse_letter_pulse_encoder_core.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------
// request   | start / busy           | item   (character, text_end)
// result    | result_valid (strobe)  | result (lamp_on, duration, last)
// config    | cfg_valid / cfg_ready  | cfg_data (unit_ticks)
//
// one segment per cycle: a letter of n elements has 2n+1 segments, a space one,
// plus one for the word gap; the segment sequencer sets the rate
// a request is taken whenever the four-entry queue has room, so start can
// follow start on the next cycle; results pass the queue and result registers
// reset empties the queue and loads unit_ticks with 100; results cannot stall
// top level of the morse letter pulse encoder; depends on mlpe_pkg,
// mlpe_front, mlpe_queue and mlpe_back
module morse_letter_pulse_encoder_core
    import mlpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [UNIT_W-1:0] cfg_data
);

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic              push;
    logic              pop;
    desc_t             push_desc;
    desc_t             head;
    queue_status_t     q_status;

    assign cfg_ready = 1'b1;
    assign busy      = q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unit_ticks_reg <= cfg_data;
        end
    end

    mlpe_front u_front (
        .start (start),
        .busy  (busy),
        .item  (item),
        .push  (push),
        .desc  (push_desc)
    );

    mlpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    mlpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_ticks   (unit_ticks_reg),
        .head         (head),
        .not_empty    (q_status.not_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // a segment is only ever shown for a queued request
    a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(q_status.not_empty))
        else $error("result strobe without a queued request");

    // the segments of one request come in consecutive cycles
    a_segments_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside the segments of one request");

    // the front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full && q_status.count < QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // an empty queue has nothing to retire
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
        else $error("queue underflow");

endmodule
